FILE: rtl/olsu_pkg.sv
// Shared types, codes and widths of the ordered list store unit.
package olsu_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;
	localparam int ST_W  = 2;
	localparam int IDX_W = 5;

	// Depth of the result queue in front of the output port.
	localparam int Q_DEPTH = 2;
	localparam int QC_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_INSERT     = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_READ_ALL   = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_MOVE,
		S_PLACE,
		S_READ
	} state_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  value;
		logic [IDX_W-1:0]         index;
		logic                     last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

endpackage

FILE: rtl/olsu_mem.sv
// Element memory: one write port, one read port with registered read data.
module olsu_mem #(
	parameter int CAPACITY = olsu_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [olsu_pkg::VAL_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [olsu_pkg::VAL_W-1:0]  rdata
);
	import olsu_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/olsu_outq.sv
// Two-entry result queue that decouples the sequencer from the output port.
module olsu_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  olsu_pkg::push_t          push,
	output logic [olsu_pkg::QC_W-1:0] count,
	output logic                     res_valid,
	input  logic                     res_stall,
	output olsu_pkg::res_t           res
);
	import olsu_pkg::*;

	res_t              ent_q [Q_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [QC_W-1:0]   count_q;
	logic              pop;

	assign pop       = res_valid && !res_stall;
	assign res_valid = (count_q != '0);
	assign res       = ent_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + QC_W'(1);
				2'b01:   count_q <= count_q - QC_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wr_ptr_q] <= push.res;
		end
	end

endmodule

FILE: rtl/olsu_ctrl.sv
// Command sequencer: list bookkeeping, insert shifting and read-out over the memory.
module olsu_ctrl #(
	parameter int CAPACITY = olsu_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [olsu_pkg::CMD_W-1:0]   command,
	input  logic [olsu_pkg::VAL_W-1:0]   value,
	input  logic [olsu_pkg::POS_W-1:0]   position,
	output logic                         we,
	output logic [AW-1:0]                waddr,
	output logic [olsu_pkg::VAL_W-1:0]   wdata,
	output logic                         re,
	output logic [AW-1:0]                raddr,
	input  logic [olsu_pkg::VAL_W-1:0]   rdata,
	input  logic [olsu_pkg::QC_W-1:0]    q_count,
	output olsu_pkg::push_t              push
);
	import olsu_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int SW = LW + 1;
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	state_t             state_q, state_d;
	logic [LW-1:0]      len_q, len_d;
	logic [AW-1:0]      head_q, head_d;
	logic [LW-1:0]      j_q, j_d;
	logic [LW-1:0]      pos_q, pos_d;
	logic [VAL_W-1:0]   val_q, val_d;
	logic [AW-1:0]      wr_addr_q, wr_addr_d;
	logic               pend_w_q, pend_w_d;
	logic               pend_q, pend_d;
	logic [LW-1:0]      pidx_q, pidx_d;
	logic               plast_q, plast_d;
	logic               accept;
	logic               credit;
	logic               full;
	logic [LW-1:0]      ins_pos;
	res_t               res;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [LW-1:0] l);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(l);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] a);
		return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
	endfunction

	function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
		return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
	endfunction

	assign cmd_stall = !(state_q == S_IDLE && !pend_q && q_count != QC_W'(Q_DEPTH));
	assign accept    = cmd_valid && !cmd_stall;
	assign credit    = ({1'b0, q_count} + (QC_W + 1)'(pend_q)) < (QC_W + 1)'(Q_DEPTH);
	assign full      = (len_q == LW'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			head_q   <= '0;
			pend_q   <= 1'b0;
			pend_w_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			len_q    <= len_d;
			head_q   <= head_d;
			pend_q   <= pend_d;
			pend_w_q <= pend_w_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q       <= j_d;
		pos_q     <= pos_d;
		val_q     <= val_d;
		wr_addr_q <= wr_addr_d;
		pidx_q    <= pidx_d;
		plast_q   <= plast_d;
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		head_d    = head_q;
		j_d       = j_q;
		pos_d     = pos_q;
		val_d     = val_q;
		wr_addr_d = wr_addr_q;
		pend_w_d  = pend_w_q;
		pend_d    = 1'b0;
		pidx_d    = pidx_q;
		plast_d   = plast_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = value;
		re        = 1'b0;
		raddr     = '0;
		ins_pos   = '0;
		res       = '{status: ST_OK, value: '0, index: '0, last: 1'b1};
		push      = '{valid: 1'b0, res: res};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					push.valid = 1'b1;
					unique case (cmd_t'(command))
						CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
							priority case (cmd_t'(command))
								CMD_PUSH_BACK:  ins_pos = len_q;
								CMD_PUSH_FRONT: ins_pos = '0;
								default:        ins_pos = LW'(position);
							endcase
							if (full) begin
								res.status = ST_FULL;
							end else if (cmd_t'(command) == CMD_INSERT &&
									CW'(position) > CW'(len_q)) begin
								res.status = ST_BADPOS;
							end else if (ins_pos == '0) begin
								// New front: step the head back one slot
								we     = 1'b1;
								waddr  = dec_wrap(head_q);
								head_d = dec_wrap(head_q);
								len_d  = len_q + LW'(1);
							end else if (ins_pos == len_q) begin
								we    = 1'b1;
								waddr = phys(head_q, len_q);
								len_d = len_q + LW'(1);
							end else begin
								// Middle insert: move the tail back one slot, last first
								pos_d    = ins_pos;
								j_d      = len_q - LW'(1);
								val_d    = value;
								pend_w_d = 1'b0;
								len_d    = len_q + LW'(1);
								state_d  = S_SHIFT;
							end
						end
						CMD_REMOVE: begin
							if (len_q == '0) begin
								res.status = ST_EMPTY;
							end else begin
								head_d = inc_wrap(head_q);
								len_d  = len_q - LW'(1);
							end
						end
						CMD_READ_ALL: begin
							if (len_q == '0) begin
								res.status = ST_EMPTY;
							end else begin
								push.valid = 1'b0;
								j_d        = '0;
								state_d    = S_READ;
							end
						end
						default: begin
						end
					endcase
					push.res = res;
				end
			end
			S_SHIFT: begin
				re    = 1'b1;
				raddr = phys(head_q, j_q);
				if (pend_w_q) begin
					we    = 1'b1;
					waddr = wr_addr_q;
					wdata = rdata;
				end
				wr_addr_d = phys(head_q, j_q + LW'(1));
				pend_w_d  = 1'b1;
				if (j_q == pos_q) begin
					state_d = S_MOVE;
				end else begin
					j_d = j_q - LW'(1);
				end
			end
			S_MOVE: begin
				we      = 1'b1;
				waddr   = wr_addr_q;
				wdata   = rdata;
				state_d = S_PLACE;
			end
			S_PLACE: begin
				we      = 1'b1;
				waddr   = phys(head_q, pos_q);
				wdata   = val_q;
				state_d = S_IDLE;
			end
			S_READ: begin
				if (credit) begin
					re      = 1'b1;
					raddr   = phys(head_q, j_q);
					pend_d  = 1'b1;
					pidx_d  = j_q;
					plast_d = (j_q == len_q - LW'(1));
					if (j_q == len_q - LW'(1)) begin
						state_d = S_IDLE;
					end else begin
						j_d = j_q + LW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Hand read data of the previous cycle to the result queue
		if (pend_q) begin
			push.valid = 1'b1;
			push.res   = '{status: ST_OK, value: rdata, index: IDX_W'(pidx_q),
				last: plast_q};
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> cmd_stall)
		else $error("command taken while a sequence runs");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_shift_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_w_q) |-> wr_addr_q != raddr)
		else $error("shift reads and writes the same entry");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> q_count != QC_W'(Q_DEPTH))
		else $error("read data arrives at a full result queue");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !accept)
		else $error("two results pushed in one cycle");

endmodule

FILE: rtl/ordered_list_store_unit.sv
// Ordered list store unit: top level joining sequencer, element memory and result queue.
//
// Keeps an ordered list of signed 32-bit values, up to CAPACITY elements, in a
// circular buffer in one synchronous memory (front at a moving head pointer).
// Every command transfer yields results through a two-entry queue, so a result
// may wait at the output while the next command is taken. Push back, push
// front, remove first, inserts at either end, error answers and unknown codes
// complete in the idle state. An insert inside the list moves the later
// elements back one slot through the single memory write port.
// Read all gives one result per element, front to back with the final one
// marked; it issues a memory read only while the two-entry queue has room for
// its data, and commands are held off until the last element has been read.
// The list is empty after reset; the memory needs no clearing.
module ordered_list_store_unit #(
	parameter int CAPACITY = olsu_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic [olsu_pkg::CMD_W-1:0]         command,
	input  logic signed [olsu_pkg::VAL_W-1:0]  value,
	input  logic [olsu_pkg::POS_W-1:0]         position,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [olsu_pkg::ST_W-1:0]          status,
	output logic signed [olsu_pkg::VAL_W-1:0]  value_res,
	output logic [olsu_pkg::IDX_W-1:0]         index,
	output logic                               last
);
	import olsu_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic              we;
	logic [AW-1:0]     waddr;
	logic [VAL_W-1:0]  wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [VAL_W-1:0]  rdata;
	logic [QC_W-1:0]   q_count;
	push_t             push;
	res_t              res;

	olsu_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.value     (value),
		.position  (position),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata),
		.q_count   (q_count),
		.push      (push)
	);

	olsu_mem #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	olsu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.count     (q_count),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign status    = res.status;
	assign value_res = res.value;
	assign index     = res.index;
	assign last      = res.last;

endmodule
